### rtl/pft_pkg.sv
package pft_pkg;

    // Result field width on the output stream
    localparam int OUT_FIELD_W = 32;

    // Results emitted per input at most; later factors only update the totient
    localparam int CNT_W = 5;
    localparam logic [CNT_W-1:0] MAX_RESULTS = 5'd31;

    // Status of the shared divider
    typedef struct packed {
        logic busy;
        logic done;
    } div_status_t;

endpackage

### rtl/prime_factorizer_with_totient.sv
// An input below two gives its single result in the cycle after acceptance. Otherwise
// each trial division is one pass of the shared restoring divider, plus one more pass
// per distinct prime for the totient; worst case about 2^(WIDTH/2) passes. Throughput:
// one input at a time; the next is taken once the last result of the previous one has
// left the output register.
// Reset: asynchronous, active low; clears the sequencer and empties the output register.
module prime_factorizer_with_totient #(
    parameter int WIDTH = 32
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [31:0] s_axis_tdata,   // [31:0] number
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [63:0] m_axis_tdata,   // [31:0] prime_factor, [63:32] totient
    output logic [0:0]  m_axis_tuser,   // [0] invalid
    output logic        m_axis_tlast
);

    localparam int OW = pft_pkg::OUT_FIELD_W;
    // Width used to cut internal values down to the result field width
    localparam int XW = (WIDTH > OW) ? WIDTH : OW;

    // Sequencer:
    //   IDLE  - wait for a transaction
    //   TRIAL - divider runs cur / d; decide divisible, next d, or finish
    //   PHI   - divider runs phi / p; phi loses phi / p
    //   ADD   - hand the new factor to the pending slot, push the old one out
    //   LAST  - push the pending factor flagged last with the totient
    typedef enum logic [2:0] {
        S_IDLE,
        S_TRIAL,
        S_PHI,
        S_ADD,
        S_LAST
    } state_t;

    state_t state_reg, state_next;

    logic [WIDTH-1:0]         cur_reg, cur_next;      // remaining cofactor
    logic [WIDTH-1:0]         phi_reg, phi_next;      // running totient
    logic [WIDTH-1:0]         d_reg, d_next;          // trial divisor
    logic [WIDTH-1:0]         cand_reg, cand_next;    // factor just found
    logic [WIDTH-1:0]         pend_reg, pend_next;    // factor waiting for its last flag
    logic [pft_pkg::CNT_W-1:0] count_reg, count_next;
    logic                     newd_reg, newd_next;    // d not yet seen as a factor
    logic                     fin_reg, fin_next;      // cofactor taken, wrap up after ADD
    logic                     start_reg, start_next;
    logic [WIDTH-1:0]         div_a_reg, div_a_next;
    logic [WIDTH-1:0]         div_b_reg, div_b_next;

    logic                     out_valid_reg, out_valid_next;
    logic [OW-1:0]            out_factor_reg, out_factor_next;
    logic [OW-1:0]            out_tot_reg, out_tot_next;
    logic                     out_inv_reg, out_inv_next;
    logic                     out_last_reg, out_last_next;

    logic [WIDTH-1:0]         n_w;
    logic [WIDTH-1:0]         div_quot;
    logic [WIDTH-1:0]         div_rem;
    pft_pkg::div_status_t     div_stat;
    logic [XW-1:0]            pend_x;
    logic [XW-1:0]            phi_x;

    pft_divider #(
        .WIDTH (WIDTH)
    ) u_div (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (start_reg),
        .dividend  (div_a_reg),
        .divisor   (div_b_reg),
        .quotient  (div_quot),
        .remainder (div_rem),
        .status    (div_stat)
    );

    assign n_w    = WIDTH'(s_axis_tdata);
    assign pend_x = XW'(pend_reg);
    assign phi_x  = XW'(phi_reg);

    assign s_axis_tready = (state_reg == S_IDLE) && !out_valid_reg;

    always_comb
    begin
        state_next      = state_reg;
        cur_next        = cur_reg;
        phi_next        = phi_reg;
        d_next          = d_reg;
        cand_next       = cand_reg;
        pend_next       = pend_reg;
        count_next      = count_reg;
        newd_next       = newd_reg;
        fin_next        = fin_reg;
        start_next      = 1'b0;
        div_a_next      = div_a_reg;
        div_b_next      = div_b_reg;
        out_valid_next  = out_valid_reg;
        out_factor_next = out_factor_reg;
        out_tot_next    = out_tot_reg;
        out_inv_next    = out_inv_reg;
        out_last_next   = out_last_reg;

        // Drop the result once the sink takes it
        if (out_valid_reg && m_axis_tready)
        begin
            out_valid_next = 1'b0;
        end

        case (state_reg)
            S_IDLE:
            begin
                if (s_axis_tvalid && s_axis_tready)
                begin
                    if (n_w < WIDTH'(2))
                    begin
                        // No factors: one invalid result carrying n as totient
                        out_valid_next  = 1'b1;
                        out_factor_next = '0;
                        out_tot_next    = {{(OW-1){1'b0}}, n_w[0]};
                        out_inv_next    = 1'b1;
                        out_last_next   = 1'b1;
                    end
                    else
                    begin
                        cur_next   = n_w;
                        phi_next   = n_w;
                        d_next     = WIDTH'(2);
                        newd_next  = 1'b1;
                        fin_next   = 1'b0;
                        count_next = '0;
                        start_next = 1'b1;
                        div_a_next = n_w;
                        div_b_next = WIDTH'(2);
                        state_next = S_TRIAL;
                    end
                end
            end

            S_TRIAL:
            begin
                if (div_stat.done)
                begin
                    if (d_reg > div_quot)
                    begin
                        // d exceeds the square root of the cofactor
                        if (cur_reg > WIDTH'(1))
                        begin
                            cand_next = cur_reg;
                            fin_next  = 1'b1;
                            if (newd_reg || cur_reg != d_reg)
                            begin
                                start_next = 1'b1;
                                div_a_next = phi_reg;
                                div_b_next = cur_reg;
                                state_next = S_PHI;
                            end
                            else
                            begin
                                // Last power of a prime already in the totient
                                state_next = S_ADD;
                            end
                        end
                        else
                        begin
                            state_next = S_LAST;
                        end
                    end
                    else if (div_rem == '0)
                    begin
                        cur_next  = div_quot;
                        cand_next = d_reg;
                        if (newd_reg)
                        begin
                            newd_next  = 1'b0;
                            start_next = 1'b1;
                            div_a_next = phi_reg;
                            div_b_next = d_reg;
                            state_next = S_PHI;
                        end
                        else
                        begin
                            state_next = S_ADD;
                        end
                    end
                    else
                    begin
                        // Advance to the next trial divisor
                        d_next     = d_reg + WIDTH'(1);
                        newd_next  = 1'b1;
                        start_next = 1'b1;
                        div_a_next = cur_reg;
                        div_b_next = d_reg + WIDTH'(1);
                    end
                end
            end

            S_PHI:
            begin
                if (div_stat.done)
                begin
                    // p divides phi exactly, so phi / p * (p - 1) = phi - phi / p
                    phi_next   = phi_reg - div_quot;
                    state_next = S_ADD;
                end
            end

            S_ADD:
            begin
                if (count_reg == '0 || count_reg == pft_pkg::MAX_RESULTS || !out_valid_reg)
                begin
                    if (count_reg == '0)
                    begin
                        pend_next  = cand_reg;
                        count_next = count_reg + pft_pkg::CNT_W'(1);
                    end
                    else if (count_reg != pft_pkg::MAX_RESULTS)
                    begin
                        out_valid_next  = 1'b1;
                        out_factor_next = pend_x[OW-1:0];
                        out_tot_next    = '0;
                        out_inv_next    = 1'b0;
                        out_last_next   = 1'b0;
                        pend_next       = cand_reg;
                        count_next      = count_reg + pft_pkg::CNT_W'(1);
                    end
                    if (fin_reg)
                    begin
                        state_next = S_LAST;
                    end
                    else
                    begin
                        start_next = 1'b1;
                        div_a_next = cur_reg;
                        div_b_next = d_reg;
                        state_next = S_TRIAL;
                    end
                end
            end

            S_LAST:
            begin
                if (!out_valid_reg)
                begin
                    out_valid_next  = 1'b1;
                    out_factor_next = pend_x[OW-1:0];
                    out_tot_next    = phi_x[OW-1:0];
                    out_inv_next    = 1'b0;
                    out_last_next   = 1'b1;
                    state_next      = S_IDLE;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            start_reg     <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            start_reg     <= start_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        cur_reg        <= cur_next;
        phi_reg        <= phi_next;
        d_reg          <= d_next;
        cand_reg       <= cand_next;
        pend_reg       <= pend_next;
        count_reg      <= count_next;
        newd_reg       <= newd_next;
        fin_reg        <= fin_next;
        div_a_reg      <= div_a_next;
        div_b_reg      <= div_b_next;
        out_factor_reg <= out_factor_next;
        out_tot_reg    <= out_tot_next;
        out_inv_reg    <= out_inv_next;
        out_last_reg   <= out_last_next;
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = {out_tot_reg, out_factor_reg};
    assign m_axis_tuser  = out_inv_reg;
    assign m_axis_tlast  = out_last_reg;

endmodule

### rtl/pft_divider.sv
module pft_divider #(
    parameter int WIDTH = 32
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 start,
    input  logic [WIDTH-1:0]     dividend,
    input  logic [WIDTH-1:0]     divisor,
    output logic [WIDTH-1:0]     quotient,
    output logic [WIDTH-1:0]     remainder,
    output pft_pkg::div_status_t status
);

    localparam int CW = $clog2(WIDTH);

    logic [WIDTH-1:0] rem_reg, rem_next;
    logic [WIDTH-1:0] quot_reg, quot_next;
    logic [WIDTH-1:0] dvs_reg, dvs_next;
    logic [CW-1:0]    cnt_reg, cnt_next;
    logic             busy_reg, busy_next;
    logic             done_reg, done_next;
    logic [WIDTH:0]   shifted;
    logic [WIDTH:0]   diff;
    logic             fits;

    // Restoring division, one quotient bit per cycle
    always_comb
    begin
        shifted   = {rem_reg, quot_reg[WIDTH-1]};
        fits      = (shifted >= {1'b0, dvs_reg});
        diff      = shifted - {1'b0, dvs_reg};
        rem_next  = rem_reg;
        quot_next = quot_reg;
        dvs_next  = dvs_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        if (start)
        begin
            rem_next  = '0;
            quot_next = dividend;
            dvs_next  = divisor;
            cnt_next  = CW'(WIDTH - 1);
            busy_next = 1'b1;
        end
        else if (busy_reg)
        begin
            rem_next  = fits ? diff[WIDTH-1:0] : shifted[WIDTH-1:0];
            quot_next = {quot_reg[WIDTH-2:0], fits};
            cnt_next  = cnt_reg - CW'(1);
            if (cnt_reg == '0)
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg  <= rem_next;
        quot_reg <= quot_next;
        dvs_reg  <= dvs_next;
        cnt_reg  <= cnt_next;
    end

    assign quotient    = quot_reg;
    assign remainder   = rem_reg;
    assign status.busy = busy_reg;
    assign status.done = done_reg;

endmodule

### sim/prime_factorizer_with_totient_tb.sv
`timescale 1ns / 100ps

module prime_factorizer_with_totient_tb;

    localparam int WIDTH = 32;

    // One factor transaction on the output stream
    typedef struct {
        logic [pft_pkg::OUT_FIELD_W-1:0] factor;
        logic [pft_pkg::OUT_FIELD_W-1:0] phi;
        logic                            invalid;
        logic                            last;
    } factor_rec_t;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [31:0] s_axis_tdata = '0;     // [31:0] number
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [63:0] m_axis_tdata;          // [31:0] prime_factor, [63:32] totient
    logic [0:0]  m_axis_tuser;          // [0] invalid
    logic        m_axis_tlast;

    logic [31:0] pending_numbers[$];
    factor_rec_t expected_factors[$];
    int          error_count = 0;
    int          cycle_count = 0;
    logic        steady;

    prime_factorizer_with_totient #(
        .WIDTH(WIDTH)
    ) dut (
        .clk(clk),
        .rst_n(rst_n),
        .s_axis_tvalid(s_axis_tvalid),
        .s_axis_tready(s_axis_tready),
        .s_axis_tdata(s_axis_tdata),
        .m_axis_tvalid(m_axis_tvalid),
        .m_axis_tready(m_axis_tready),
        .m_axis_tdata(m_axis_tdata),
        .m_axis_tuser(m_axis_tuser),
        .m_axis_tlast(m_axis_tlast)
    );

    initial
    begin
        forever #2 clk = ~clk;
    end

    // Window of cycles in which neither side idles
    assign steady = (cycle_count >= 100000) && (cycle_count < 200000);

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
    end

    // Append a number to the stimulus queue
    function automatic void queue_number(input logic [31:0] num);
        pending_numbers.insert(pending_numbers.size(), num);
    endfunction

    // Append a factor transaction to the expected queue
    function automatic void queue_expected(input factor_rec_t rec);
        expected_factors.insert(expected_factors.size(), rec);
    endfunction

    // Factorize one number by trial division and queue the factor transactions it
    // must produce, in ascending order. The totient rides on the last one only.
    function automatic void factorize(input logic [31:0] value);
        logic [63:0] n;
        logic [63:0] cur;
        logic [63:0] phi;
        logic [63:0] d;
        logic [63:0] factors[64];
        int          count;
        int          emit;
        factor_rec_t rec;
        n = {32'd0, value} & ((64'd1 << WIDTH) - 64'd1);
        count = 0;
        if (n < 64'd2)
        begin
            rec.factor  = '0;
            rec.phi     = n[pft_pkg::OUT_FIELD_W-1:0];
            rec.invalid = 1'b1;
            rec.last    = 1'b1;
            queue_expected(rec);
            return;
        end
        cur = n;
        phi = n;
        d   = 64'd2;
        while (d <= cur / d)
        begin
            if (cur % d == 64'd0)
            begin
                // Scale the totient once per distinct prime, then strip every power of it
                phi = phi / d * (d - 64'd1);
                while (cur % d == 64'd0)
                begin
                    if (count < 64)
                    begin
                        factors[count] = d;
                        count = count + 1;
                    end
                    cur = cur / d;
                end
            end
            d = d + 64'd1;
        end
        // A cofactor left above one is the largest prime factor
        if (cur > 64'd1)
        begin
            phi = phi / cur * (cur - 64'd1);
            if (count < 64)
            begin
                factors[count] = cur;
                count = count + 1;
            end
        end
        emit = (count < int'(pft_pkg::MAX_RESULTS)) ? count : int'(pft_pkg::MAX_RESULTS);
        for (int k = 0; k < emit; k++)
        begin
            rec.factor  = factors[k][pft_pkg::OUT_FIELD_W-1:0];
            rec.phi     = (k == emit - 1) ? phi[pft_pkg::OUT_FIELD_W-1:0] : '0;
            rec.invalid = 1'b0;
            rec.last    = (k == emit - 1);
            queue_expected(rec);
        end
    endfunction

    // Driver: on each accepted number, predict its factors, then offer the next
    // pending number or idle at random.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s_axis_tvalid <= 1'b0;
            s_axis_tdata  <= '0;
        end
        else if (!s_axis_tvalid || s_axis_tready)
        begin
            if (s_axis_tvalid && s_axis_tready)
            begin
                factorize(s_axis_tdata);
            end
            if (pending_numbers.size() != 0 && (steady || $urandom_range(99) >= 38))
            begin
                s_axis_tvalid <= 1'b1;
                s_axis_tdata  <= pending_numbers.pop_front();
            end
            else
            begin
                s_axis_tvalid <= 1'b0;
            end
        end
    end

    // Monitor: stall the output at random and compare each accepted transaction
    // with the oldest expected factor.
    always @(posedge clk or negedge rst_n)
    begin
        factor_rec_t want;
        if (!rst_n)
        begin
            m_axis_tready <= 1'b0;
        end
        else
        begin
            m_axis_tready <= steady || ($urandom_range(99) >= 38);
            if (m_axis_tvalid && m_axis_tready)
            begin
                if (expected_factors.size() == 0)
                begin
                    $error("unexpected transaction: factor %0d totient %0d",
                           m_axis_tdata[31:0], m_axis_tdata[63:32]);
                    error_count = error_count + 1;
                end
                else
                begin
                    want = expected_factors.pop_front();
                    if (m_axis_tdata[31:0] !== want.factor)
                    begin
                        $error("prime_factor: expected %0d, got %0d",
                               want.factor, m_axis_tdata[31:0]);
                        error_count = error_count + 1;
                    end
                    if (m_axis_tdata[63:32] !== want.phi)
                    begin
                        $error("totient: expected %0d, got %0d",
                               want.phi, m_axis_tdata[63:32]);
                        error_count = error_count + 1;
                    end
                    if (m_axis_tuser[0] !== want.invalid)
                    begin
                        $error("invalid: expected %0b, got %0b",
                               want.invalid, m_axis_tuser[0]);
                        error_count = error_count + 1;
                    end
                    if (m_axis_tlast !== want.last)
                    begin
                        $error("last: expected %0b, got %0b", want.last, m_axis_tlast);
                        error_count = error_count + 1;
                    end
                end
            end
        end
    end

    // Stimulus and end of run
    initial
    begin
        logic [63:0] value;
        int          steps;
        int          f;

        // Directed: below two, tiny primes, prime powers, 31 results, all-ones
        queue_number(32'd0);
        queue_number(32'd1);
        queue_number(32'd2);
        queue_number(32'd3);
        queue_number(32'd4);
        queue_number(32'd7);
        queue_number(32'd12);
        queue_number(32'd49);
        queue_number(32'd1024);
        queue_number(32'd30030);
        queue_number(32'd65521);
        queue_number(32'd1000003);
        queue_number(32'd3486784401);
        queue_number(32'h8000_0000);
        queue_number(32'hC000_0000);
        queue_number(32'hFFFF_FFFF);
        queue_number(32'h5555_5555);
        queue_number(32'hAAAA_AAAA);
        queue_number(32'd65537);
        queue_number(32'd999_999_999);

        // Random: mostly products of small factors on a modest cofactor, so the
        // trial division stays short while the value reaches all 32 bits.
        for (int i = 0; i < 80; i++)
        begin
            if ($urandom_range(9) < 8)
            begin
                value = 64'($urandom_range(16383, 1));
                steps = $urandom_range(40);
                for (int s = 0; s < steps; s++)
                begin
                    f = $urandom_range(127, 2);
                    if (value * f <= 64'hFFFF_FFFF)
                    begin
                        value = value * f;
                    end
                end
            end
            else if ($urandom_range(1) == 0)
            begin
                value = 64'($urandom_range(3));
            end
            else
            begin
                value = 64'($urandom_range(65535));
            end
            queue_number(value[31:0]);
        end

        repeat (8) @(posedge clk);
        rst_n <= 1'b1;

        // Hold until every number is accepted and every factor has arrived
        while (pending_numbers.size() != 0 || s_axis_tvalid)
        begin
            @(posedge clk);
        end
        while (expected_factors.size() != 0)
        begin
            @(posedge clk);
        end
        repeat (64) @(posedge clk);

        if (expected_factors.size() != 0)
        begin
            $error("%0d expected factors never arrived", expected_factors.size());
        end
        if (error_count == 0 && expected_factors.size() == 0)
        begin
            $display("Simulation PASSED");
        end
        else
        begin
            $display("Simulation FAILED");
        end
        $finish;
    end

    // Drop the run if it hangs
    initial
    begin
        #100_000_000;
        $display("Simulation FAILED");
        $finish;
    end

endmodule
